// ===== rtl/core/afr_pkg.sv =====
// afr_pkg: constants, codes, keyword table and result payload type of the
// ascii frame receiver. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package afr_pkg;

  localparam int FRAME_LEN  = 64;
  localparam int MAX_FIELDS = 8;
  localparam int FIELD_LEN  = 16;

  localparam int PTR_W  = $clog2(FRAME_LEN);
  localparam int FILL_W = $clog2(FRAME_LEN + 1);
  localparam int NF_W   = $clog2(MAX_FIELDS + 1);
  localparam int FIDX_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int FL_W   = $clog2(FIELD_LEN);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SIZE    = 3'd1;
  localparam logic [2:0] ST_NOTYPE  = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_OVF     = 3'd4;

  localparam int NUM_KEYS = 14;
  localparam int KW_MAX   = 11;

  localparam logic [8*KW_MAX-1:0] KW_STR [NUM_KEYS] = '{
    "HELLO", "CMD", "ACK", "DONE", "NACK", "STATE", "METRIC", "SENSOR",
    "OUTPUT", "EVENT", "ERROR", {"ERROR", "_CLEAR"}, "CONFIG", "SNAPSHOT"
  };
  localparam int KW_LEN [NUM_KEYS] = '{5, 3, 3, 4, 4, 5, 6, 6, 6, 5, 5, 11, 6, 8};

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [3:0] frame_type;
    logic [3:0] num_fields;
    logic [2:0] field_number;
    logic [7:0] text_byte;
    logic       field_end;
    logic       last;
  } res_t;

  // keywords whose character at position idx equals c
  function automatic logic [NUM_KEYS-1:0] kw_hits(input logic [7:0] c,
                                                  input logic [FILL_W-1:0] idx);
    logic [NUM_KEYS-1:0] h;
    h = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (int'(idx) < KW_LEN[k]) begin
        h[k] = (KW_STR[k][8*(KW_LEN[k]-1-int'(idx)) +: 8] == c);
      end
    end
    return h;
  endfunction

  // keywords of exactly len characters
  function automatic logic [NUM_KEYS-1:0] kw_len_eq(input logic [FILL_W-1:0] len);
    logic [NUM_KEYS-1:0] h;
    for (int k = 0; k < NUM_KEYS; k++) begin
      h[k] = (int'(len) == KW_LEN[k]);
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/afr_if.sv =====
// afr_if: valid/ready channel interfaces for received bytes and results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface afr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface afr_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] status;
  logic [3:0] frame_type;
  logic [3:0] num_fields;
  logic [2:0] field_number;
  logic [7:0] text_byte;
  logic       field_end;
  logic       last;
  modport source (output valid, output kind, output status, output frame_type,
                  output num_fields, output field_number, output text_byte,
                  output field_end, output last, input ready);
  modport sink (input valid, input kind, input status, input frame_type,
                input num_fields, input field_number, input text_byte,
                input field_end, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ascii_frame_receiver.sv =====
// ascii_frame_receiver: frame buffer, token scanner and field emitter.
// Depends on afr_pkg, afr_if and afr_result_reg.
//
// rx carries one received byte per item, res one result item: a frame header
// (kind 0) and, on a good frame, every field byte (kind 1), last on the final
// one. Bytes are stored in a 64-entry buffer memory with a registered read.
// An ordinary byte is stored and rx stays ready. A '>' closing a frame of
// two or more buffered bytes starts a decode: the scanner walks the buffer
// byte by byte (read, then evaluate against the keyword table), then the
// header is sent, then the emitter walks the fields again, reading each byte
// and then sending it unless it is a comma. rx is not ready meanwhile. A
// shorter frame only sends a size-error header. Overflow, start and
// outside-frame bytes need no scan; an overflow only sends its header.
// A stalled res holds the item in its output register; rx is taken again while
// a last result still waits. Reset empties the frame and output register; the
// buffer itself is not cleared, only entries of the current frame are read.
`timescale 1ns / 1ps
`default_nettype none
module ascii_frame_receiver (
  input  wire logic clk,
  input  wire logic rst,
  afr_rx_if.sink    rx,
  afr_res_if.source res
);

  localparam int PTR_W  = afr_pkg::PTR_W;
  localparam int FILL_W = afr_pkg::FILL_W;
  localparam int NF_W   = afr_pkg::NF_W;
  localparam int FIDX_W = afr_pkg::FIDX_W;
  localparam int FL_W   = afr_pkg::FL_W;
  localparam int NK     = afr_pkg::NUM_KEYS;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN_RD = 3'd1;
  localparam logic [2:0] S_SCAN_EV = 3'd2;
  localparam logic [2:0] S_HDR     = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_EV = 3'd5;

  logic [2:0]        state;
  logic              in_frame;
  logic [FILL_W-1:0] fill;
  logic [7:0]        mem [afr_pkg::FRAME_LEN];
  logic [7:0]        rdata;
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  end_pos;
  logic              in_tok;
  logic              have_type;
  logic [FILL_W-1:0] tok_len;
  logic [NK-1:0]     cand;
  logic [3:0]        ftype;
  logic [NF_W-1:0]   nf;
  logic [FL_W-1:0]   flen [afr_pkg::MAX_FIELDS];
  logic [2:0]        hdr_status;
  logic [PTR_W-1:0]  emit_start;
  logic [NF_W-1:0]   fcur;
  logic [FL_W-1:0]   bcnt;

  logic              acc;
  logic              mem_we;
  logic [PTR_W-1:0]  wa;
  logic              is_end;
  logic              is_comma;
  logic              do_finish;
  logic [NK-1:0]     kw_final;
  logic              kw_hit;
  logic [3:0]        kw_code;
  logic              field_bad;
  logic              fend;
  logic              flast;
  logic              slot_free;
  logic              res_load;
  afr_pkg::res_t     res_d;

  assign rx.ready = (state == S_IDLE);
  assign acc      = rx.valid && rx.ready;

  // buffer memory
  always_comb begin
    wa     = (rx.rx_byte == afr_pkg::CH_LT) ? '0 : fill[PTR_W-1:0];
    mem_we = acc && ((rx.rx_byte == afr_pkg::CH_LT) ||
             (in_frame && fill < FILL_W'(afr_pkg::FRAME_LEN - 1)));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wa] <= rx.rx_byte;
    end
    rdata <= mem[ptr];
  end

  // token evaluation
  always_comb begin
    is_end    = (ptr == end_pos);
    is_comma  = (rdata == afr_pkg::CH_COMMA);
    do_finish = in_tok && (is_end || is_comma);
    kw_final  = cand & afr_pkg::kw_len_eq(tok_len);
    kw_hit    = |kw_final;
    kw_code   = '0;
    for (int k = NK - 1; k >= 0; k--) begin
      if (kw_final[k]) begin
        kw_code = 4'(k);
      end
    end
    field_bad = (nf >= NF_W'(afr_pkg::MAX_FIELDS)) ||
                (tok_len >= FILL_W'(afr_pkg::FIELD_LEN));
    fend      = (bcnt == flen[fcur[FIDX_W-1:0]] - 1'b1);
    flast     = fend && (fcur == nf - 1'b1);
  end

  // result payload
  always_comb begin
    res_d = '0;
    res_load = 1'b0;
    if (state == S_HDR) begin
      res_load         = slot_free;
      res_d.status     = hdr_status;
      res_d.frame_type = ftype;
      res_d.num_fields = (hdr_status == afr_pkg::ST_OK) ? 4'(nf) : 4'd0;
      res_d.last       = (hdr_status != afr_pkg::ST_OK) || (nf == '0);
    end else if (state == S_EMIT_EV && !is_comma) begin
      res_load           = slot_free;
      res_d.kind         = 1'b1;
      res_d.status       = afr_pkg::ST_OK;
      res_d.frame_type   = ftype;
      res_d.num_fields   = 4'(nf);
      res_d.field_number = 3'(fcur);
      res_d.text_byte    = rdata;
      res_d.field_end    = fend;
      res_d.last         = flast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_frame <= 1'b0;
      fill     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (rx.rx_byte == afr_pkg::CH_LT) begin
              in_frame <= 1'b1;
              fill     <= FILL_W'(1);
            end else if (in_frame) begin
              if (fill >= FILL_W'(afr_pkg::FRAME_LEN - 1)) begin
                in_frame   <= 1'b0;
                fill       <= '0;
                hdr_status <= afr_pkg::ST_OVF;
                ftype      <= '0;
                nf         <= '0;
                state      <= S_HDR;
              end else if (rx.rx_byte == afr_pkg::CH_GT) begin
                in_frame  <= 1'b0;
                fill      <= '0;
                ftype     <= '0;
                nf        <= '0;
                in_tok    <= 1'b0;
                have_type <= 1'b0;
                ptr       <= PTR_W'(1);
                end_pos   <= fill[PTR_W-1:0];
                if (fill < FILL_W'(2)) begin
                  hdr_status <= afr_pkg::ST_SIZE;
                  state      <= S_HDR;
                end else begin
                  state <= S_SCAN_RD;
                end
              end else begin
                fill <= fill + 1'b1;
              end
            end
          end
        end
        S_SCAN_RD: state <= S_SCAN_EV;
        S_SCAN_EV: begin
          if (do_finish && !have_type && !kw_hit) begin
            hdr_status <= afr_pkg::ST_UNKNOWN;
            state      <= S_HDR;
          end else if (do_finish && have_type && field_bad) begin
            hdr_status <= afr_pkg::ST_SIZE;
            state      <= S_HDR;
          end else begin
            if (do_finish) begin
              if (!have_type) begin
                have_type  <= 1'b1;
                ftype      <= kw_code;
                emit_start <= ptr;
              end else begin
                flen[nf[FIDX_W-1:0]] <= tok_len[FL_W-1:0];
                nf <= nf + 1'b1;
              end
            end
            if (is_end) begin
              hdr_status <= (have_type || do_finish) ? afr_pkg::ST_OK : afr_pkg::ST_NOTYPE;
              state      <= S_HDR;
            end else begin
              if (is_comma) begin
                in_tok <= 1'b0;
              end else if (!in_tok) begin
                in_tok  <= 1'b1;
                tok_len <= FILL_W'(1);
                cand    <= afr_pkg::kw_hits(rdata, '0);
              end else begin
                tok_len <= tok_len + 1'b1;
                cand    <= cand & afr_pkg::kw_hits(rdata, tok_len);
              end
              ptr   <= ptr + 1'b1;
              state <= S_SCAN_RD;
            end
          end
        end
        S_HDR: begin
          if (slot_free) begin
            fcur <= '0;
            bcnt <= '0;
            ptr  <= emit_start;
            state <= (hdr_status == afr_pkg::ST_OK && nf != '0) ? S_EMIT_RD : S_IDLE;
          end
        end
        S_EMIT_RD: state <= S_EMIT_EV;
        S_EMIT_EV: begin
          if (is_comma) begin
            ptr   <= ptr + 1'b1;
            state <= S_EMIT_RD;
          end else if (slot_free) begin
            ptr <= ptr + 1'b1;
            if (fend) begin
              fcur <= fcur + 1'b1;
              bcnt <= '0;
            end else begin
              bcnt <= bcnt + 1'b1;
            end
            state <= flast ? S_IDLE : S_EMIT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  afr_result_reg u_res (
    .clk  (clk),
    .rst  (rst),
    .load (res_load),
    .din  (res_d),
    .free (slot_free),
    .res  (res)
  );

  // no result is produced while taking bytes
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !res_load) else $error("result load while idle");

  // a closing byte inside a long enough frame starts the scan
  a_close_scan: assert property (@(posedge clk) disable iff (rst)
    (acc && in_frame && rx.rx_byte == afr_pkg::CH_GT && fill >= FILL_W'(2) &&
     fill < FILL_W'(afr_pkg::FRAME_LEN - 1)) |=> state == S_SCAN_RD)
    else $error("frame end did not start scan");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill < FILL_W'(afr_pkg::FRAME_LEN)) else $error("fill count overrun");

  a_nf_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> nf <= NF_W'(afr_pkg::MAX_FIELDS))
    else $error("field count overrun");

endmodule
`default_nettype wire

// ===== rtl/core/afr_result_reg.sv =====
// afr_result_reg: output register holding one result item until taken.
// Depends on afr_pkg and afr_if.
`timescale 1ns / 1ps
`default_nettype none
module afr_result_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire afr_pkg::res_t din,
  output logic               free,
  afr_res_if.source          res
);

  logic          valid;
  afr_pkg::res_t data;

  assign free = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data <= din;
    end
  end

  assign res.valid        = valid;
  assign res.kind         = data.kind;
  assign res.status       = data.status;
  assign res.frame_type   = data.frame_type;
  assign res.num_fields   = data.num_fields;
  assign res.field_number = data.field_number;
  assign res.text_byte    = data.text_byte;
  assign res.field_end    = data.field_end;
  assign res.last         = data.last;

endmodule
`default_nettype wire

// ===== tb/ascii_frame_receiver_tb.sv =====
// ascii_frame_receiver_tb: self-checking bench for the ascii frame receiver,
// with a frame-decoding predictor, random idling on both channels and a result checker.
// Depends on afr_pkg, afr_if and ascii_frame_receiver.
`timescale 1ns / 1ps
`default_nettype none
module ascii_frame_receiver_tb;

  logic clk;
  logic rst;

  afr_rx_if  rx ();
  afr_res_if res ();

  ascii_frame_receiver i_dut (.clk(clk), .rst(rst), .rx(rx), .res(res));

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state
  logic [7:0]        buf_q [afr_pkg::FRAME_LEN];
  int                fill_q;
  bit                open_q;

  logic [7:0]       byte_queue [$];
  afr_pkg::res_t    expected_results [$];
  int               error_count;
  int               send_idle_pct;
  int               recv_idle_pct;
  bit               hold_recv;
  bit               rx_taken;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic afr_pkg::res_t mk_res(input logic kind, input logic [2:0] st,
                                           input int ty, input int cnt, input int num,
                                           input logic [7:0] b, input logic fe,
                                           input logic lst);
    afr_pkg::res_t r;
    r.kind = kind; r.status = st; r.frame_type = 4'(ty);
    r.num_fields = 4'(cnt); r.field_number = 3'(num);
    r.text_byte = b; r.field_end = fe; r.last = lst;
    return r;
  endfunction

  function automatic int lookup_keyword(input int start, input int len);
    bit hit;
    for (int k = 0; k < afr_pkg::NUM_KEYS; k++) begin
      if (afr_pkg::KW_LEN[k] == len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++)
          if (buf_q[start + i] != afr_pkg::KW_STR[k][8*(len-1-i) +: 8]) hit = 1'b0;
        if (hit) return k;
      end
    end
    return afr_pkg::NUM_KEYS;
  endfunction

  task automatic decode_frame();
    int fs [afr_pkg::MAX_FIELDS];
    int fl [afr_pkg::MAX_FIELDS];
    int nf, ty, pos, stop, start, len;
    bit have_ty;
    nf = 0; ty = 0; pos = 1; have_ty = 1'b0;
    if (fill_q < 3) begin
      expected_results.push_back(mk_res(0, afr_pkg::ST_SIZE, 0, 0, 0, 0, 0, 1));
      return;
    end
    stop = fill_q - 1;
    forever begin
      while (pos < stop && buf_q[pos] == afr_pkg::CH_COMMA) pos++;
      if (pos >= stop) break;
      start = pos;
      while (pos < stop && buf_q[pos] != afr_pkg::CH_COMMA) pos++;
      len = pos - start;
      if (!have_ty) begin
        ty = lookup_keyword(start, len);
        if (ty >= afr_pkg::NUM_KEYS) begin
          expected_results.push_back(mk_res(0, afr_pkg::ST_UNKNOWN, 0, 0, 0, 0, 0, 1));
          return;
        end
        have_ty = 1'b1;
      end else begin
        if (nf >= afr_pkg::MAX_FIELDS || len >= afr_pkg::FIELD_LEN) begin
          expected_results.push_back(mk_res(0, afr_pkg::ST_SIZE, ty, 0, 0, 0, 0, 1));
          return;
        end
        fs[nf] = start; fl[nf] = len; nf++;
      end
    end
    if (!have_ty) begin
      expected_results.push_back(mk_res(0, afr_pkg::ST_NOTYPE, 0, 0, 0, 0, 0, 1));
      return;
    end
    expected_results.push_back(mk_res(0, afr_pkg::ST_OK, ty, nf, 0, 0, 0, nf == 0));
    for (int f = 0; f < nf; f++)
      for (int b = 0; b < fl[f]; b++)
        expected_results.push_back(mk_res(1, afr_pkg::ST_OK, ty, nf, f, buf_q[fs[f] + b],
                                          b + 1 == fl[f],
                                          (b + 1 == fl[f]) && (f + 1 == nf)));
  endtask

  task automatic predict_byte(input logic [7:0] c);
    if (c == afr_pkg::CH_LT) begin
      open_q = 1'b1; buf_q[0] = c; fill_q = 1;
    end else if (open_q) begin
      if (fill_q >= afr_pkg::FRAME_LEN - 1) begin
        open_q = 1'b0; fill_q = 0;
        expected_results.push_back(mk_res(0, afr_pkg::ST_OVF, 0, 0, 0, 0, 0, 1));
      end else begin
        buf_q[fill_q] = c;
        fill_q++;
        if (c == afr_pkg::CH_GT) begin
          decode_frame();
          open_q = 1'b0; fill_q = 0;
        end
      end
    end
  endtask

  // driver: a new item only once the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      rx.valid <= 1'b0;
      rx.rx_byte <= '0;
    end else if (!rx.valid || rx_taken) begin
      if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        rx.valid <= 1'b1;
        rx.rx_byte <= byte_queue[0];
      end else begin
        rx.valid <= 1'b0;
      end
    end
  end

  // prediction runs on accepted bytes
  always @(posedge clk) begin
    rx_taken <= !rst && rx.valid && rx.ready;
    if (!rst && rx.valid && rx.ready) begin
      predict_byte(rx.rx_byte);
      void'(byte_queue.pop_front());
    end
  end

  always @(negedge clk) begin
    if (rst || hold_recv) res.ready <= 1'b0;
    else res.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    afr_pkg::res_t got, want;
    if (!rst && res.valid && res.ready) begin
      got = mk_res(res.kind, res.status, res.frame_type, res.num_fields,
                   res.field_number, res.text_byte, res.field_end, res.last);
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result %h", got));
      end else begin
        want = expected_results.pop_front();
        if (got.kind != want.kind) report("kind");
        if (got.status != want.status) report("status");
        if (got.frame_type != want.frame_type) report("frame_type");
        if (got.num_fields != want.num_fields) report("num_fields");
        if (got.field_number != want.field_number) report("field_number");
        if (got.text_byte != want.text_byte) report("text_byte");
        if (got.field_end != want.field_end) report("field_end");
        if (got.last != want.last) report("last");
      end
    end
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
  endtask

  function automatic string kw_text(input int k);
    string s;
    s = "";
    for (int i = 0; i < afr_pkg::KW_LEN[k]; i++)
      s = {s, string'(afr_pkg::KW_STR[k][8*(afr_pkg::KW_LEN[k]-1-i) +: 8])};
    return s;
  endfunction

  function automatic string rand_field(input int maxlen);
    string s;
    int n;
    byte c;
    s = "";
    n = $urandom_range(maxlen, 1);
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(255));
      if (c == afr_pkg::CH_LT || c == afr_pkg::CH_GT || c == afr_pkg::CH_COMMA) c = "x";
      s = {s, string'(c)};
    end
    return s;
  endfunction

  // well-formed frame with random content, sometimes broken
  task automatic push_random_frame();
    string s;
    int nf, r;
    r = $urandom_range(99);
    s = "<";
    if (r < 10) s = {s, rand_field(4)};
    else s = {s, kw_text($urandom_range(afr_pkg::NUM_KEYS-1))};
    nf = $urandom_range(r < 20 ? 9 : 3, 0);
    for (int f = 0; f < nf; f++) begin
      s = {s, ","};
      if ($urandom_range(9) == 0) s = {s, ","};
      s = {s, rand_field(r < 30 ? 16 : 4)};
    end
    if (s.len() > 60) s = s.substr(0, 59);
    if ($urandom_range(9) == 0) byte_queue.push_back(8'($urandom_range(255)));
    push_text({s, ">"});
  endtask

  task automatic wait_drained();
    while (byte_queue.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    send_idle_pct = 37; recv_idle_pct = 60;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // sender idles more rarely: stray byte, empty fields, zero byte, empty,
    // commas only, unknown keyword, restart
    push_text("a<HELLO>");
    push_text("<ERROR");
    push_text("_CLEAR,a,,");
    byte_queue.push_back(8'h00); byte_queue.push_back(8'hFF);
    push_text(">");
    push_text("<>");
    push_text("<,,>");
    push_text("<FOO>");
    push_text("<STATE<NACK,x>");
    wait_drained();

    // receiver idles more rarely: too many fields, field too long
    send_idle_pct = 60; recv_idle_pct = 37;
    push_text("<ACK,1,2,3,4,5,6,7,8,9>");
    push_text("<DONE,0123456789abcdef>");
    wait_drained();

    // long receiver hold-off while an overflow and another frame keep coming
    send_idle_pct = 0; recv_idle_pct = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (400) @(posedge clk);
        hold_recv = 1'b0;
      end
    join_none
    byte_queue.push_back(afr_pkg::CH_LT);
    for (int i = 0; i < 63; i++) byte_queue.push_back("a");
    push_text("<CMD,1>");
    wait_drained();

    for (int n = 0; n < 2; n++) push_random_frame();
    wait_drained();

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
